@@ hdl/pss_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the plucked-string synthesizer core.
// No dependencies; used by the channel interfaces and the core.
package pss_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W        = 16;
  localparam int unsigned DELAY_LENGTH_W  = 11;
  localparam int unsigned FEEDBACK_GAIN_W = 16;
  localparam int unsigned CFG_DATA_W      = 16;
  localparam int unsigned CFG_INDEX_W     = 2;

  // Default delay store depth
  localparam int unsigned MAX_DELAY_DEFAULT = 1024;

  // Register reset values
  localparam logic [DELAY_LENGTH_W-1:0]  DELAY_LENGTH_RESET  = 11'd100;
  localparam logic [FEEDBACK_GAIN_W-1:0] FEEDBACK_GAIN_RESET = 16'd64880;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DELAY_LENGTH  = 2'd0,
    REG_FEEDBACK_GAIN = 2'd1
  } cfg_reg_t;

  // Request kinds
  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_TICK = 1'b1
  } req_kind_t;

endpackage

@@ hdl/pss_req_if.sv @@
`timescale 1ns / 1ps
// Request channel: valid/ready handshake carrying the request type and load value.
// Depends on pss_pkg.
interface pss_req_if;
  logic                valid;
  logic                ready;
  logic                req_type;
  pss_pkg::sample_t    load_value;

  modport source (output valid, output req_type, output load_value, input ready);
  modport sink   (input valid, input req_type, input load_value, output ready);
endinterface

@@ hdl/pss_rsp_if.sv @@
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying one generated sample.
// Depends on pss_pkg.
interface pss_rsp_if;
  logic                valid;
  logic                ready;
  pss_pkg::sample_t    sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

@@ hdl/plucked_string_synth_core.sv @@
`timescale 1ns / 1ps
// Plucked-string synthesizer core: delay store, feedback filter and result buffer.
// Depends on pss_pkg, pss_req_if and pss_rsp_if.

// The core takes one request per clock cycle with no gaps, as long as results are
// taken as they come. A load request writes one excitation sample at the current
// position and returns nothing; a tick request returns the stored sample at the
// current position and writes back (current + next) * feedback_gain >> 17. Each
// request is read from the delay store on the edge it is accepted (two read ports,
// current and next entry) and written back on the following edge; a forwarding path
// covers back-to-back requests that touch the same entry, so the sustained rate is
// one request per cycle while results are taken. A tick's sample passes through the
// pipeline stage into a two-entry result buffer, from which it is offered on the
// result port; requests stall only while that buffer would overflow. The store
// has no reset: every entry must be loaded before a tick reads it. Writing
// delay_length sets the position to zero; write registers only while no request is
// in flight.
module plucked_string_synth_core #(
  parameter int unsigned MAX_DELAY = pss_pkg::MAX_DELAY_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [pss_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [pss_pkg::CFG_DATA_W-1:0]     cfg_data,
  pss_req_if.sink                            req,
  pss_rsp_if.source                          rsp
);

  localparam int unsigned AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int unsigned LW = $clog2(MAX_DELAY + 1);
  localparam int unsigned CW = (LW > pss_pkg::DELAY_LENGTH_W) ? LW : pss_pkg::DELAY_LENGTH_W;
  localparam logic [CW-1:0] MAX_LEN = CW'(MAX_DELAY);

  // Configuration registers
  logic [pss_pkg::DELAY_LENGTH_W-1:0]  delay_length;
  logic [pss_pkg::FEEDBACK_GAIN_W-1:0] feedback_gain;

  // Position and pipeline stage
  logic [AW-1:0]     pos;
  logic [AW-1:0]     pos_next;
  logic              s_valid;
  logic              s_type;
  pss_pkg::sample_t  s_load;
  logic [AW-1:0]     s_addr;

  // Delay store and its read/forward registers
  logic [pss_pkg::SAMPLE_W-1:0] store [MAX_DELAY];
  pss_pkg::sample_t  rd_cur;
  pss_pkg::sample_t  rd_nxt;
  logic              fwd_cur_hit;
  logic              fwd_nxt_hit;
  pss_pkg::sample_t  fwd_data;

  // Result buffer
  pss_pkg::sample_t  fifo [2];
  logic              wptr;
  logic              rptr;
  logic [1:0]        count;

  // Combinational signals
  logic [CW-1:0]     len;
  logic [CW-1:0]     pos_ext;
  logic [AW-1:0]     pos_eff;
  logic [CW-1:0]     nxt_ext;
  logic [AW-1:0]     nxt_addr;
  logic              accept;
  logic              push;
  logic              pop;
  logic [2:0]        room_chk;
  pss_pkg::sample_t  cur_val;
  pss_pkg::sample_t  nxt_val;
  logic signed [16:0] pair_sum;
  logic signed [16:0] gain_s;
  logic signed [33:0] prod;
  logic signed [16:0] scaled;
  pss_pkg::sample_t  fb_val;
  pss_pkg::sample_t  wdata;

  // Active length, clamped to 1..MAX_DELAY
  always_comb begin
    if (delay_length == '0) begin
      len = CW'(1);
    end else if (CW'(delay_length) > MAX_LEN) begin
      len = MAX_LEN;
    end else begin
      len = CW'(delay_length);
    end
  end

  // Current and next addresses
  always_comb begin
    pos_ext  = CW'(pos);
    pos_eff  = (pos_ext >= len) ? '0 : pos;
    nxt_ext  = CW'(pos_eff) + CW'(1);
    nxt_addr = (nxt_ext >= len) ? '0 : nxt_ext[AW-1:0];
    pos_next = nxt_addr;
  end

  // Handshake: accept only if the buffer will have room when this request's result lands
  assign pop      = (count != 2'd0) && rsp.ready;
  assign push     = s_valid && (s_type == pss_pkg::REQ_TICK);
  assign room_chk = {1'b0, count} + {2'b00, push} - {2'b00, pop};
  assign req.ready = (room_chk < 3'd2);
  assign accept   = req.valid && req.ready;

  // Feedback filter on forwarded read data
  always_comb begin
    cur_val  = fwd_cur_hit ? fwd_data : rd_cur;
    nxt_val  = fwd_nxt_hit ? fwd_data : rd_nxt;
    pair_sum = {cur_val[15], cur_val} + {nxt_val[15], nxt_val};
    gain_s   = signed'({1'b0, feedback_gain});
    prod     = pair_sum * gain_s;
    scaled   = prod[33:17];
    // saturate, though the range of the operands keeps it in Q1.15
    if (scaled[16] != scaled[15]) begin
      fb_val = scaled[16] ? 16'sh8000 : 16'sh7fff;
    end else begin
      fb_val = scaled[15:0];
    end
    wdata = (s_type == pss_pkg::REQ_TICK) ? fb_val : s_load;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_length  <= pss_pkg::DELAY_LENGTH_RESET;
      feedback_gain <= pss_pkg::FEEDBACK_GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pss_pkg::REG_DELAY_LENGTH:  delay_length  <= cfg_data[pss_pkg::DELAY_LENGTH_W-1:0];
        pss_pkg::REG_FEEDBACK_GAIN: feedback_gain <= cfg_data[pss_pkg::FEEDBACK_GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Position and stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      s_valid <= 1'b0;
    end else begin
      s_valid <= accept;
      if (cfg_we && (cfg_index == pss_pkg::REG_DELAY_LENGTH)) begin
        pos <= '0;
      end else if (accept) begin
        pos <= pos_next;
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s_type <= req.req_type;
      s_load <= req.load_value;
      s_addr <= pos_eff;
    end
  end

  // Delay store: two reads, one write-back, forward the write of this cycle
  always_ff @(posedge clk) begin
    if (s_valid) begin
      store[s_addr] <= wdata;
    end
    rd_cur      <= store[pos_eff];
    rd_nxt      <= store[nxt_addr];
    fwd_cur_hit <= s_valid && (s_addr == pos_eff);
    fwd_nxt_hit <= s_valid && (s_addr == nxt_addr);
    fwd_data    <= wdata;
  end

  // Result buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= room_chk[1:0];
    end
  end

  // Result buffer data
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wptr] <= cur_val;
    end
  end

  assign rsp.valid      = (count != 2'd0);
  assign rsp.sample_out = fifo[rptr];

endmodule
